@@ rtl/eulerian_circuit_engine_assert.svh @@
// ----------------------------------------------------------------------------
// Eulerian circuit engine assertion macros
// Clocked implication checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef EULERIAN_CIRCUIT_ENGINE_ASSERT_SVH
`define EULERIAN_CIRCUIT_ENGINE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ECE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eulerian circuit engine check failed");

// consequent must hold in the cycle after the antecedent
`define ECE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eulerian circuit engine check failed");

`endif

@@ rtl/ece_pkg.sv @@
// ----------------------------------------------------------------------------
// Eulerian circuit engine package
// Shared constants, command and status codes, and the result beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package ece_pkg;

  localparam int MAX_VERTICES_DEF   = 16;
  localparam int MAX_DEGREE_DEF     = 16;
  localparam int MAX_EDGES_DEF      = 32;
  localparam int VERTEX_COUNT_RESET = 16;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_REMOVE  = 2'd1;
  localparam logic [1:0] CMD_DEGREE  = 2'd2;
  localparam logic [1:0] CMD_CIRCUIT = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_RANGE      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [2:0] ST_NO_CIRCUIT = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] value;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/ece_out_reg.sv @@
// ----------------------------------------------------------------------------
// Eulerian circuit engine result register
// One-entry output stage holding a result beat until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ece_out_reg import ece_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t din,
  input  logic out_stall,
  output logic ready,
  output logic out_valid,
  output res_t dout
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      dout <= din;
    end
  end

  // free when empty or when the held beat leaves this cycle
  assign ready = !out_valid || !out_stall;

endmodule

`default_nettype wire

@@ rtl/eulerian_circuit_engine.sv @@
// ----------------------------------------------------------------------------
// Eulerian circuit engine
// Holds an undirected multigraph as per-vertex neighbour lists and answers
// add, remove, degree and circuit commands, one command at a time. An add
// reads both list lengths and appends an entry to each endpoint's list (one
// entry for a self loop); a degree query or a range error goes straight to
// its response. A remove scans and shifts the entries of each endpoint's
// list. The circuit command makes three passes over the stored lists
// (connectivity walk, parity check, walk-list build), then runs the
// Hierholzer steps and emits the circuit one vertex per result beat. The
// passes share the single read port of the neighbour store.
// in_stall is high from acceptance until the last result beat is loaded
// into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module eulerian_circuit_engine import ece_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_DEGREE   = MAX_DEGREE_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [3:0]         vertex_a,
  input  logic [3:0]         vertex_b,
  input  logic signed [31:0] edge_weight,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [4:0]         result_value,
  output logic               last_item
);

  localparam int VW          = $clog2(MAX_VERTICES);
  localparam int NW          = $clog2(MAX_VERTICES + 1);
  localparam int DW          = $clog2(MAX_DEGREE);
  localparam int LW          = $clog2(MAX_DEGREE + 1);
  localparam int WALK_DEGREE = 2 * MAX_DEGREE;
  localparam int WDW         = $clog2(WALK_DEGREE);
  localparam int WLW         = $clog2(WALK_DEGREE + 1);
  localparam int EW          = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int TW          = $clog2(MAX_EDGES + 1);
  localparam int SD          = MAX_EDGES + 1;
  localparam int SW          = $clog2(SD);
  localparam int SPW         = $clog2(SD + 1);
  localparam int NB_DEPTH    = 1 << (VW + DW);
  localparam int WK_DEPTH    = 1 << (VW + WDW);
  localparam int N_RESET     = (VERTEX_COUNT_RESET > MAX_VERTICES) ? MAX_VERTICES
                                                                   : VERTEX_COUNT_RESET;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_RESP    = 5'd1;
  localparam logic [4:0] S_ADD_A   = 5'd2;
  localparam logic [4:0] S_ADD_B   = 5'd3;
  localparam logic [4:0] S_ADD_W2  = 5'd4;
  localparam logic [4:0] S_DR_LEN  = 5'd5;
  localparam logic [4:0] S_DR_RD   = 5'd6;
  localparam logic [4:0] S_DR_CMP  = 5'd7;
  localparam logic [4:0] S_SH_RD   = 5'd8;
  localparam logic [4:0] S_SH_WR   = 5'd9;
  localparam logic [4:0] S_CS_SCAN = 5'd10;
  localparam logic [4:0] S_DFS_POP = 5'd11;
  localparam logic [4:0] S_DFS_LEN = 5'd12;
  localparam logic [4:0] S_DFS_RD  = 5'd13;
  localparam logic [4:0] S_DFS_CHK = 5'd14;
  localparam logic [4:0] S_PAR_LEN = 5'd15;
  localparam logic [4:0] S_PAR_RD  = 5'd16;
  localparam logic [4:0] S_PAR_CHK = 5'd17;
  localparam logic [4:0] S_BL_LEN  = 5'd18;
  localparam logic [4:0] S_BL_RD   = 5'd19;
  localparam logic [4:0] S_BL_CHK  = 5'd20;
  localparam logic [4:0] S_BL_P2   = 5'd21;
  localparam logic [4:0] S_HZ_TOP  = 5'd22;
  localparam logic [4:0] S_HZ_V    = 5'd23;
  localparam logic [4:0] S_HZ_CHK  = 5'd24;
  localparam logic [4:0] S_HZ_EDGE = 5'd25;
  localparam logic [4:0] S_EM_RD   = 5'd26;
  localparam logic [4:0] S_EM_OUT  = 5'd27;

  logic [4:0]       st;
  logic [NW-1:0]    n;
  logic [TW-1:0]    total;
  logic [LW-1:0]    lens [MAX_VERTICES];
  logic [WLW-1:0]   wlen [MAX_VERTICES];
  logic [VW-1:0]    dstk [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] vis;
  logic [MAX_EDGES-1:0]    used;

  logic [VW-1:0]    va, vb, dv, dd, hv, hstart;
  logic [31:0]      wreg;
  logic [LW-1:0]    la, lb, dlen, di;
  logic             second, par;
  logic [NW-1:0]    ci, dsp;
  logic [TW-1:0]    k;
  logic [SPW-1:0]   sp, clen;
  logic [SW-1:0]    ei;
  res_t             res;

  // neighbour and weight stores
  logic [VW-1:0]    nb_mem [NB_DEPTH];
  logic [31:0]      wt_mem [NB_DEPTH];
  logic [VW+DW-1:0] nb_raddr, nb_waddr;
  logic             nb_we;
  logic [VW-1:0]    nb_wdata, nb_rd;
  logic [31:0]      wt_wdata, wt_rd;

  // walk lists
  logic [VW-1:0]     wnb_mem [WK_DEPTH];
  logic [EW-1:0]     wid_mem [WK_DEPTH];
  logic [VW+WDW-1:0] w_raddr, w_waddr;
  logic              w_we;
  logic [VW-1:0]     w_wnb, wnb_rd;
  logic [EW-1:0]     w_wid, wid_rd;

  // vertex stack and circuit buffer
  logic [VW-1:0]  vs_mem [SD];
  logic [VW-1:0]  cb_mem [SD];
  logic           vs_we, cb_we;
  logic [SW-1:0]  vs_waddr, vs_raddr, cb_waddr;
  logic [VW-1:0]  vs_wdata, vs_rd, cb_wdata, cb_rd;

  logic [VW-1:0]  lrd_idx, wl_idx;
  logic [LW-1:0]  len_rd;
  logic [WLW-1:0] wl_cur;
  logic           add_full, a_bad, b_bad;
  logic           push, out_ready;
  res_t           din, dout;

  assign in_stall = (st != S_IDLE);
  assign a_bad    = int'(vertex_a) >= int'(n);
  assign b_bad    = int'(vertex_b) >= int'(n);

  always_comb begin
    unique case (st)
      S_IDLE:                        lrd_idx = VW'(vertex_a);
      S_ADD_A:                       lrd_idx = va;
      S_ADD_B:                       lrd_idx = vb;
      S_CS_SCAN, S_PAR_LEN, S_BL_LEN: lrd_idx = VW'(ci);
      default:                       lrd_idx = dv;
    endcase
  end

  assign len_rd = lens[lrd_idx];

  always_comb begin
    unique case (st)
      S_BL_CHK: wl_idx = dv;
      S_BL_P2:  wl_idx = dd;
      default:  wl_idx = hv;
    endcase
  end

  assign wl_cur = wlen[wl_idx];

  assign add_full = (int'(total) >= MAX_EDGES) || (int'(la) >= MAX_DEGREE) ||
                    ((va != vb) && (int'(len_rd) >= MAX_DEGREE));

  always_comb begin
    nb_raddr = {dv, DW'(di)};
    nb_we    = 1'b0;
    nb_waddr = {va, DW'(la)};
    nb_wdata = vb;
    wt_wdata = wreg;
    w_raddr  = {hv, WDW'(wl_cur - 1'b1)};
    w_we     = 1'b0;
    w_waddr  = {dv, WDW'(wl_cur)};
    w_wnb    = nb_rd;
    w_wid    = EW'(k);
    vs_we    = 1'b0;
    vs_waddr = SW'(sp);
    vs_wdata = wnb_rd;
    vs_raddr = SW'(sp - 1'b1);
    cb_we    = 1'b0;
    cb_waddr = SW'(clen);
    cb_wdata = hv;
    unique case (st)
      S_ADD_B: begin
        nb_we = !add_full;
      end
      S_ADD_W2: begin
        nb_we    = 1'b1;
        nb_waddr = {vb, DW'(lb)};
        nb_wdata = va;
      end
      S_SH_RD: begin
        nb_raddr = {dv, DW'(int'(di) + 1)};
      end
      S_SH_WR: begin
        nb_we    = 1'b1;
        nb_waddr = {dv, DW'(di)};
        nb_wdata = nb_rd;
        wt_wdata = wt_rd;
      end
      S_BL_LEN: begin
        // seed the walk stack with the start vertex
        vs_we    = int'(ci) >= int'(n);
        vs_waddr = '0;
        vs_wdata = hstart;
      end
      S_BL_CHK: begin
        w_we = (dv <= nb_rd) && (int'(k) < MAX_EDGES) && (int'(wl_cur) < WALK_DEGREE);
      end
      S_BL_P2: begin
        w_we    = int'(wl_cur) < WALK_DEGREE;
        w_waddr = {dd, WDW'(wl_cur)};
        w_wnb   = dv;
      end
      S_HZ_CHK: begin
        cb_we = (wl_cur == '0) && (int'(clen) < SD);
      end
      S_HZ_EDGE: begin
        vs_we = !used[wid_rd] && (int'(sp) < SD);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nb_we) begin
      nb_mem[nb_waddr] <= nb_wdata;
      wt_mem[nb_waddr] <= wt_wdata;
    end
    nb_rd <= nb_mem[nb_raddr];
    wt_rd <= wt_mem[nb_raddr];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wnb_mem[w_waddr] <= w_wnb;
      wid_mem[w_waddr] <= w_wid;
    end
    wnb_rd <= wnb_mem[w_raddr];
    wid_rd <= wid_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (vs_we) begin
      vs_mem[vs_waddr] <= vs_wdata;
    end
    vs_rd <= vs_mem[vs_raddr];
  end

  always_ff @(posedge clk) begin
    if (cb_we) begin
      cb_mem[cb_waddr] <= cb_wdata;
    end
    cb_rd <= cb_mem[ei];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      n     <= NW'(N_RESET);
      total <= '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        lens[i] <= '0;
        wlen[i] <= '0;
      end
    end else begin
      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            va     <= VW'(vertex_a);
            vb     <= VW'(vertex_b);
            dv     <= VW'(vertex_a);
            dd     <= VW'(vertex_b);
            wreg   <= edge_weight;
            second <= 1'b0;
            ci     <= '0;
            unique case (command)
              CMD_CIRCUIT: begin
                st <= S_CS_SCAN;
              end
              CMD_DEGREE: begin
                if (a_bad) begin
                  res <= '{status: ST_RANGE, value: 5'd0, last: 1'b1};
                end else begin
                  res <= '{status: ST_OK, value: 5'(len_rd), last: 1'b1};
                end
                st <= S_RESP;
              end
              default: begin
                if (a_bad || b_bad) begin
                  res <= '{status: ST_RANGE, value: 5'd0, last: 1'b1};
                  st  <= S_RESP;
                end else if (command == CMD_ADD) begin
                  st <= S_ADD_A;
                end else begin
                  st <= S_DR_LEN;
                end
              end
            endcase
          end
        end
        S_RESP: begin
          if (out_ready) begin
            st <= S_IDLE;
          end
        end
        S_ADD_A: begin
          la <= len_rd;
          st <= S_ADD_B;
        end
        S_ADD_B: begin
          lb <= len_rd;
          if (add_full) begin
            res <= '{status: ST_FULL, value: 5'd0, last: 1'b1};
            st  <= S_RESP;
          end else begin
            lens[va] <= la + 1'b1;
            if (va != vb) begin
              st <= S_ADD_W2;
            end else begin
              total <= total + 1'b1;
              res   <= '{status: ST_OK, value: 5'd0, last: 1'b1};
              st    <= S_RESP;
            end
          end
        end
        S_ADD_W2: begin
          lens[vb] <= lb + 1'b1;
          total    <= total + 1'b1;
          res      <= '{status: ST_OK, value: 5'd0, last: 1'b1};
          st       <= S_RESP;
        end
        S_DR_LEN: begin
          dlen <= len_rd;
          di   <= '0;
          st   <= S_DR_RD;
        end
        S_DR_RD: begin
          if (di >= dlen) begin
            if (!second) begin
              res <= '{status: ST_NOT_FOUND, value: 5'd0, last: 1'b1};
            end else begin
              if (total != '0) total <= total - 1'b1;
              res <= '{status: ST_OK, value: 5'd0, last: 1'b1};
            end
            st <= S_RESP;
          end else begin
            st <= S_DR_CMP;
          end
        end
        S_DR_CMP: begin
          if (nb_rd == dd) begin
            st <= S_SH_RD;
          end else begin
            di <= di + 1'b1;
            st <= S_DR_RD;
          end
        end
        S_SH_RD: begin
          if (int'(di) + 1 >= int'(dlen)) begin
            lens[dv] <= dlen - 1'b1;
            if (!second && (va != vb)) begin
              // now drop the mirror entry from the other endpoint
              dv     <= vb;
              dd     <= va;
              second <= 1'b1;
              st     <= S_DR_LEN;
            end else begin
              if (total != '0) total <= total - 1'b1;
              res <= '{status: ST_OK, value: 5'd0, last: 1'b1};
              st  <= S_RESP;
            end
          end else begin
            st <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          di <= di + 1'b1;
          st <= S_SH_RD;
        end
        S_CS_SCAN: begin
          if (int'(ci) >= int'(n)) begin
            res <= '{status: ST_OK, value: 5'd0, last: 1'b1};
            st  <= S_RESP;
          end else if (len_rd != '0) begin
            hstart          <= VW'(ci);
            vis             <= MAX_VERTICES'(1) << VW'(ci);
            dstk[0]         <= VW'(ci);
            dsp             <= NW'(1);
            st              <= S_DFS_POP;
          end else begin
            ci <= ci + 1'b1;
          end
        end
        S_DFS_POP: begin
          if (dsp == '0) begin
            ci <= '0;
            st <= S_PAR_LEN;
          end else begin
            dv  <= dstk[VW'(dsp - 1'b1)];
            dsp <= dsp - 1'b1;
            st  <= S_DFS_LEN;
          end
        end
        S_DFS_LEN: begin
          dlen <= len_rd;
          di   <= '0;
          st   <= S_DFS_RD;
        end
        S_DFS_RD: begin
          st <= (di >= dlen) ? S_DFS_POP : S_DFS_CHK;
        end
        S_DFS_CHK: begin
          if (!vis[nb_rd] && (int'(dsp) < MAX_VERTICES)) begin
            vis[nb_rd]     <= 1'b1;
            dstk[VW'(dsp)] <= nb_rd;
            dsp            <= dsp + 1'b1;
          end
          di <= di + 1'b1;
          st <= S_DFS_RD;
        end
        S_PAR_LEN: begin
          if (int'(ci) >= int'(n)) begin
            ci   <= '0;
            k    <= '0;
            used <= '0;
            for (int i = 0; i < MAX_VERTICES; i++) begin
              wlen[i] <= '0;
            end
            st <= S_BL_LEN;
          end else begin
            dv   <= VW'(ci);
            dlen <= len_rd;
            di   <= '0;
            par  <= 1'b0;
            if ((len_rd != '0) && !vis[VW'(ci)]) begin
              res <= '{status: ST_NO_CIRCUIT, value: 5'd0, last: 1'b1};
              st  <= S_RESP;
            end else begin
              st <= S_PAR_RD;
            end
          end
        end
        S_PAR_RD: begin
          if (di >= dlen) begin
            if (par) begin
              res <= '{status: ST_NO_CIRCUIT, value: 5'd0, last: 1'b1};
              st  <= S_RESP;
            end else begin
              ci <= ci + 1'b1;
              st <= S_PAR_LEN;
            end
          end else begin
            st <= S_PAR_CHK;
          end
        end
        S_PAR_CHK: begin
          // self loops are skipped, so they leave the parity alone
          if (nb_rd != dv) par <= !par;
          di <= di + 1'b1;
          st <= S_PAR_RD;
        end
        S_BL_LEN: begin
          if (int'(ci) >= int'(n)) begin
            sp   <= SPW'(1);
            hv   <= hstart;
            clen <= '0;
            st   <= S_HZ_CHK;
          end else begin
            dv   <= VW'(ci);
            dlen <= len_rd;
            di   <= '0;
            st   <= S_BL_RD;
          end
        end
        S_BL_RD: begin
          if (di >= dlen) begin
            ci <= ci + 1'b1;
            st <= S_BL_LEN;
          end else begin
            st <= S_BL_CHK;
          end
        end
        S_BL_CHK: begin
          dd <= nb_rd;
          if ((dv <= nb_rd) && (int'(k) < MAX_EDGES)) begin
            if (int'(wl_cur) < WALK_DEGREE) wlen[dv] <= wl_cur + 1'b1;
            st <= S_BL_P2;
          end else begin
            di <= di + 1'b1;
            st <= S_BL_RD;
          end
        end
        S_BL_P2: begin
          if (int'(wl_cur) < WALK_DEGREE) wlen[dd] <= wl_cur + 1'b1;
          k  <= k + 1'b1;
          di <= di + 1'b1;
          st <= S_BL_RD;
        end
        S_HZ_TOP: begin
          if (sp == '0) begin
            ei <= SW'(clen - 1'b1);
            st <= S_EM_RD;
          end else begin
            st <= S_HZ_V;
          end
        end
        S_HZ_V: begin
          hv <= vs_rd;
          st <= S_HZ_CHK;
        end
        S_HZ_CHK: begin
          if (wl_cur != '0) begin
            st <= S_HZ_EDGE;
          end else begin
            if (int'(clen) < SD) clen <= clen + 1'b1;
            sp <= sp - 1'b1;
            st <= S_HZ_TOP;
          end
        end
        S_HZ_EDGE: begin
          // drop the tail entry whether or not its edge is spent
          wlen[hv] <= wl_cur - 1'b1;
          if (!used[wid_rd]) begin
            used[wid_rd] <= 1'b1;
            if (int'(sp) < SD) begin
              sp <= sp + 1'b1;
              hv <= wnb_rd;
            end
          end
          st <= S_HZ_CHK;
        end
        S_EM_RD: begin
          st <= S_EM_OUT;
        end
        S_EM_OUT: begin
          if (out_ready) begin
            if (ei == '0) begin
              st <= S_IDLE;
            end else begin
              ei <= ei - 1'b1;
              st <= S_EM_RD;
            end
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase

      if (cfg_wen) begin
        if (cfg_wdata == '0) begin
          n <= NW'(1);
        end else if (int'(cfg_wdata) > MAX_VERTICES) begin
          n <= NW'(MAX_VERTICES);
        end else begin
          n <= NW'(cfg_wdata);
        end
        total <= '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
          lens[i] <= '0;
        end
      end
    end
  end

  assign push = ((st == S_RESP) || (st == S_EM_OUT)) && out_ready;

  always_comb begin
    if (st == S_EM_OUT) begin
      din = '{status: ST_OK, value: 5'(cb_rd), last: (ei == '0)};
    end else begin
      din = res;
    end
  end

  ece_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (din),
    .out_stall (out_stall),
    .ready     (out_ready),
    .out_valid (out_valid),
    .dout      (dout)
  );

  assign status       = dout.status;
  assign result_value = dout.value;
  assign last_item    = dout.last;

endmodule

`default_nettype wire

@@ rtl/ece_checker.sv @@
// ----------------------------------------------------------------------------
// Eulerian circuit engine checker
// Port-level checks on the engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "eulerian_circuit_engine_assert.svh"

module ece_checker import ece_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] status,
  input wire logic [4:0] result_value,
  input wire logic       last_item
);

  // a held result beat keeps its payload
  `ECE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(result_value) && $stable(last_item))

  // an accepted command always leaves the engine busy in the next cycle
  `ECE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // error results are single beats with a zero value
  `ECE_ASSERT_NOW(a_error_single, out_valid && (status != ST_OK), last_item && (result_value == 5'd0))

endmodule

bind eulerian_circuit_engine ece_checker u_ece_checker (.*);

`default_nettype wire
